// ===== sv/dmx_pkg.sv =====
`timescale 1ns / 1ps

package dmx_pkg;

   // slot memory depth and derived widths
   localparam int SLOT_COUNT = 512;
   localparam int SLOT_AW    = $clog2(SLOT_COUNT);

   // fixed field widths
   localparam int ADDR_W  = 10;
   localparam int SLOTS_W = 10;
   localparam int BYTE_W  = 8;
   localparam int TICK_W  = 4;
   localparam int PHASE_W = 10;

   // register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_SEL_W  = 3;

   typedef enum logic [REG_SEL_W-1:0] {
      REG_DEVICE_ADDRESS  = 3'd0,
      REG_MAX_SLOTS       = 3'd1,
      REG_LEVEL_THRESHOLD = 3'd2,
      REG_RENEW_TICKS     = 3'd3,
      REG_BLINK_TICKS     = 3'd4
   } reg_index_type;

   // register reset values
   localparam logic [ADDR_W-1:0]  DEVICE_ADDRESS_RST  = 10'd1;
   localparam logic [SLOTS_W-1:0] MAX_SLOTS_RST       = 10'd512;
   localparam logic [BYTE_W-1:0]  LEVEL_THRESHOLD_RST = 8'd125;
   localparam logic [TICK_W-1:0]  RENEW_TICKS_RST     = 4'd10;
   localparam logic [TICK_W-1:0]  BLINK_TICKS_RST     = 4'd3;

   // item opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // frame phase encoding: idle, waiting for start code, then 2 + slot count
   localparam logic [PHASE_W-1:0] PHASE_IDLE  = 10'd0;
   localparam logic [PHASE_W-1:0] PHASE_WAIT  = 10'd1;
   localparam logic [PHASE_W-1:0] PHASE_SLOT0 = 10'd2;

   localparam logic [TICK_W-1:0] TIMEOUT_RST = 4'd10;

endpackage

// ===== sv/dmx512_frame_receiver_top.sv =====
`timescale 1ns / 1ps

// DMX512 device-side frame receiver.
// Input channel (req_*): one item per transfer, either a UART byte (opcode 0,
// with rx_byte and break_seen) or a 200 ms timer tick (opcode 1).
// Result channel (rsp_*): exactly one result per input item, holding the
// level indicator, the activity light and the slot count of the current frame.
// The result is registered: an item accepted at one edge has its result valid
// after that edge. One item per cycle is sustained unless stalled; the slot
// memory has one write port and one registered read port for the watched slot.
// The cycle after a register write the input is stalled so the watched slot
// read can follow the new device address.
// When the result consumer stalls, the result register holds and the input
// is stalled until that result is taken.
// Reset (synchronous) restores the register defaults, idles the frame logic
// and empties the slot memory logically: a fill count marks how far the
// memory was ever written, unwritten slots read as zero, so no clearing
// pass is needed and items are accepted right after reset.
// Registers sit at byte addresses 0,4,8,12,16 on the APB-style port.
module dmx512_frame_receiver_top (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [dmx_pkg::BYTE_W-1:0]          req_rx_byte,
   input  logic                                req_break_seen,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_level_on,
   output logic                                rsp_activity_on,
   output logic [dmx_pkg::SLOTS_W-1:0]         rsp_slots_received,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dmx_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [dmx_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [dmx_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   // configuration registers
   logic [dmx_pkg::ADDR_W-1:0]  device_address_ff;
   logic [dmx_pkg::SLOTS_W-1:0] max_slots_ff;
   logic [dmx_pkg::BYTE_W-1:0]  level_threshold_ff;
   logic [dmx_pkg::TICK_W-1:0]  renew_ticks_ff;
   logic [dmx_pkg::TICK_W-1:0]  blink_ticks_ff;
   logic                        cfg_wr_ff;

   // frame state
   logic [dmx_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [dmx_pkg::TICK_W-1:0]  timeout_ff, timeout_in;
   logic                        activity_ff, activity_in;
   logic                        level_ff, level_in;
   logic [dmx_pkg::SLOTS_W-1:0] fill_ff, fill_in;

   // slot memory
   logic [dmx_pkg::BYTE_W-1:0]  slot_mem [dmx_pkg::SLOT_COUNT];
   logic [dmx_pkg::BYTE_W-1:0]  rd_data_ff;
   logic                        wr_en;
   logic [dmx_pkg::SLOT_AW-1:0] wr_addr;
   logic [dmx_pkg::BYTE_W-1:0]  wr_data;
   logic                        last_wr_ff;
   logic [dmx_pkg::SLOT_AW-1:0] last_wr_addr_ff;
   logic [dmx_pkg::BYTE_W-1:0]  last_wr_data_ff;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_level_ff;
   logic                        rsp_activity_ff;
   logic [dmx_pkg::SLOTS_W-1:0] rsp_slots_ff;

   logic                        accept;
   logic                        cfg_write;
   dmx_pkg::reg_index_type      reg_sel;
   logic [dmx_pkg::ADDR_W-1:0]  watch_num;
   logic [dmx_pkg::SLOT_AW-1:0] watch_idx;
   logic [dmx_pkg::BYTE_W-1:0]  watch_val;
   logic [dmx_pkg::SLOTS_W-1:0] limit;
   logic [dmx_pkg::SLOTS_W-1:0] slot_cnt;
   logic [dmx_pkg::SLOTS_W-1:0] slot_cnt_next;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign reg_sel   = dmx_pkg::reg_index_type'(paddr[dmx_pkg::CSR_ADDR_W-1:2]);
   assign cfg_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff  <= dmx_pkg::DEVICE_ADDRESS_RST;
         max_slots_ff       <= dmx_pkg::MAX_SLOTS_RST;
         level_threshold_ff <= dmx_pkg::LEVEL_THRESHOLD_RST;
         renew_ticks_ff     <= dmx_pkg::RENEW_TICKS_RST;
         blink_ticks_ff     <= dmx_pkg::BLINK_TICKS_RST;
         cfg_wr_ff          <= 1'b0;
      end else begin
         cfg_wr_ff <= cfg_write;
         if (cfg_write) begin
            case (reg_sel)
               dmx_pkg::REG_DEVICE_ADDRESS:
                  device_address_ff <= pwdata[dmx_pkg::ADDR_W-1:0];
               dmx_pkg::REG_MAX_SLOTS:
                  max_slots_ff <= pwdata[dmx_pkg::SLOTS_W-1:0];
               dmx_pkg::REG_LEVEL_THRESHOLD:
                  level_threshold_ff <= pwdata[dmx_pkg::BYTE_W-1:0];
               dmx_pkg::REG_RENEW_TICKS:
                  renew_ticks_ff <= pwdata[dmx_pkg::TICK_W-1:0];
               dmx_pkg::REG_BLINK_TICKS:
                  blink_ticks_ff <= pwdata[dmx_pkg::TICK_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (reg_sel)
         dmx_pkg::REG_DEVICE_ADDRESS:
            prdata = dmx_pkg::CSR_DATA_W'(device_address_ff);
         dmx_pkg::REG_MAX_SLOTS:
            prdata = dmx_pkg::CSR_DATA_W'(max_slots_ff);
         dmx_pkg::REG_LEVEL_THRESHOLD:
            prdata = dmx_pkg::CSR_DATA_W'(level_threshold_ff);
         dmx_pkg::REG_RENEW_TICKS:
            prdata = dmx_pkg::CSR_DATA_W'(renew_ticks_ff);
         dmx_pkg::REG_BLINK_TICKS:
            prdata = dmx_pkg::CSR_DATA_W'(blink_ticks_ff);
         default:
            prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   // result register frees up when it is empty or being taken this cycle
   assign req_stall = (rsp_valid_ff & rsp_stall) | cfg_wr_ff;
   assign accept    = req_valid & ~req_stall;

   // ---------------- watched slot ----------------
   // address 0 means slot 1; anything past the end means the last slot
   always_comb begin
      watch_num = device_address_ff;
      if (watch_num == '0)
         watch_num = dmx_pkg::ADDR_W'(1);
      if (watch_num > dmx_pkg::ADDR_W'(dmx_pkg::SLOT_COUNT))
         watch_num = dmx_pkg::ADDR_W'(dmx_pkg::SLOT_COUNT);
   end

   assign watch_idx = dmx_pkg::SLOT_AW'(watch_num - dmx_pkg::ADDR_W'(1));

   // read port follows the watched slot every cycle; a write on the edge
   // that loaded rd_data_ff is forwarded, slots past the fill count are zero
   always_comb begin
      if (last_wr_ff && last_wr_addr_ff == watch_idx)
         watch_val = last_wr_data_ff;
      else if (dmx_pkg::SLOTS_W'(watch_idx) < fill_ff)
         watch_val = rd_data_ff;
      else
         watch_val = '0;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[watch_idx];
      if (wr_en)
         slot_mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      last_wr_addr_ff <= wr_addr;
      last_wr_data_ff <= wr_data;
      if (reset)
         last_wr_ff <= 1'b0;
      else
         last_wr_ff <= wr_en;
   end

   // ---------------- frame logic ----------------
   assign limit = (max_slots_ff > dmx_pkg::SLOTS_W'(dmx_pkg::SLOT_COUNT))
                  ? dmx_pkg::SLOTS_W'(dmx_pkg::SLOT_COUNT) : max_slots_ff;
   assign slot_cnt      = phase_ff - dmx_pkg::PHASE_SLOT0;
   assign slot_cnt_next = slot_cnt + dmx_pkg::SLOTS_W'(1);
   assign wr_addr       = slot_cnt[dmx_pkg::SLOT_AW-1:0];
   assign wr_data       = req_rx_byte;

   always_comb begin
      phase_in    = phase_ff;
      timeout_in  = timeout_ff;
      activity_in = activity_ff;
      level_in    = level_ff;
      fill_in     = fill_ff;
      wr_en       = 1'b0;
      if (accept) begin
         if (req_opcode == dmx_pkg::OP_TICK) begin
            if (timeout_ff != '0) begin
               timeout_in = timeout_ff - dmx_pkg::TICK_W'(1);
            end else begin
               timeout_in  = blink_ticks_ff;
               activity_in = ~activity_ff;
            end
         end else if (req_break_seen) begin
            phase_in = dmx_pkg::PHASE_WAIT;
            level_in = (watch_val >= level_threshold_ff);
         end else if (phase_ff == dmx_pkg::PHASE_WAIT) begin
            timeout_in = renew_ticks_ff;
            if (req_rx_byte == '0)
               phase_in = dmx_pkg::PHASE_SLOT0;
         end else if (phase_ff >= dmx_pkg::PHASE_SLOT0 && slot_cnt < limit) begin
            wr_en = 1'b1;
            if (slot_cnt_next > fill_ff)
               fill_in = slot_cnt_next;
            // a full frame of slots sends the phase back to idle
            if (slot_cnt_next == dmx_pkg::SLOTS_W'(dmx_pkg::SLOT_COUNT))
               phase_in = dmx_pkg::PHASE_IDLE;
            else
               phase_in = phase_ff + dmx_pkg::PHASE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dmx_pkg::PHASE_IDLE;
         timeout_ff  <= dmx_pkg::TIMEOUT_RST;
         activity_ff <= 1'b1;
         level_ff    <= 1'b0;
         fill_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         timeout_ff  <= timeout_in;
         activity_ff <= activity_in;
         level_ff    <= level_in;
         fill_ff     <= fill_in;
      end
   end

   // ---------------- result register ----------------
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_level_ff    <= level_in;
         rsp_activity_ff <= activity_in;
         rsp_slots_ff    <= (phase_in >= dmx_pkg::PHASE_SLOT0)
                            ? dmx_pkg::SLOTS_W'(phase_in - dmx_pkg::PHASE_SLOT0) : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_on       = rsp_level_ff;
   assign rsp_activity_on    = rsp_activity_ff;
   assign rsp_slots_received = rsp_slots_ff;

endmodule

// ===== sv/dmx_checker.sv =====
`timescale 1ns / 1ps

module dmx_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_level_on,
   input logic                        rsp_activity_on,
   input logic [dmx_pkg::SLOTS_W-1:0] rsp_slots_received
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_level_on)
         && $stable(rsp_activity_on) && $stable(rsp_slots_received))
      else $error("result changed while stalled");

   // every accepted item yields a result on the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

   // no new transfer in while the pending result is blocked
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while result register blocked");

   // slot count stays within one frame
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slots_received < dmx_pkg::SLOTS_W'(dmx_pkg::SLOT_COUNT))
      else $error("slot count out of range");

endmodule

bind dmx512_frame_receiver_top dmx_checker u_dmx_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_level_on       (rsp_level_on),
   .rsp_activity_on    (rsp_activity_on),
   .rsp_slots_received (rsp_slots_received)
);
